// ----- src/ntfsdr_pkg.sv -----
// ----------------------------------------------------------------------------
// ntfsdr_pkg
// Shared types and constants for the NTFS data run decoder.
// ----------------------------------------------------------------------------
package ntfsdr_pkg;

    // Field widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned FIELD_W   = 64;
    localparam int unsigned LANES     = FIELD_W / BYTE_W;
    localparam int unsigned SIZE_W    = 4;
    localparam int unsigned STATUS_W  = 2;

    // Largest byte count of either header field
    localparam logic [SIZE_W-1:0] MAX_FIELD_BYTES = SIZE_W'(LANES);

    // Result kind carried on the master tuser
    typedef enum logic [STATUS_W-1:0] {
        ST_RUN = 2'd0,
        ST_END = 2'd1,
        ST_BAD = 2'd2
    } t_status;

endpackage

// ----- src/ntfs_data_run_decoder_top.sv -----
// ----------------------------------------------------------------------------
// ntfs_data_run_decoder_top
// Decodes an NTFS run list, one byte per transfer, into run length and
// starting cluster results.
// ----------------------------------------------------------------------------
// Each byte of the run list is one slave transfer; tuser set marks the first
// byte of a new list (a header) and clears the running cluster. The block
// takes one byte every cycle while the master side drains. A byte passes an
// input register, then the header decode, byte gather, sign fill and the
// 64-bit cluster add settle into the result register, which drives o_m_tvalid
// when the byte that completes a result has passed through both registers.
// A result is given for every completed run (tuser 0), for a zero
// header (end of list, tuser 1) and for a header with bad sizes (tuser 2);
// after the last two, bytes are dropped until the next transfer with tuser set.
// ----------------------------------------------------------------------------
module ntfs_data_run_decoder_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,     // [7:0] run_byte
    input  logic         i_s_tuser,     // [0] start_list
    // master side
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [127:0] o_m_tdata,     // [63:0] run_length, [127:64] start_cluster
    output logic [1:0]   o_m_tuser      // [1:0] status
);

    localparam int unsigned BW = ntfsdr_pkg::BYTE_W;
    localparam int unsigned FW = ntfsdr_pkg::FIELD_W;
    localparam int unsigned NL = ntfsdr_pkg::LANES;
    localparam int unsigned SW = ntfsdr_pkg::SIZE_W;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_DELTA,
        PH_STOP
    } t_phase;

    // input register
    logic          r_in_valid;
    logic [BW-1:0] r_in_byte;
    logic          r_in_start;

    // parser state
    t_phase        r_phase;
    logic [SW-1:0] r_count;
    logic [SW-1:0] r_len_bytes;
    logic [SW-1:0] r_dlt_bytes;
    logic [FW-1:0] r_len_acc;
    logic [FW-1:0] r_dlt_acc;
    logic [FW-1:0] r_prev;

    // result register
    logic                  r_out_valid;
    ntfsdr_pkg::t_status   r_out_status;
    logic [FW-1:0]         r_out_len;
    logic [FW-1:0]         r_out_start;

    // next values
    t_phase                n_phase;
    logic [SW-1:0]         n_count;
    logic [SW-1:0]         n_len_bytes;
    logic [SW-1:0]         n_dlt_bytes;
    logic [FW-1:0]         n_len_acc;
    logic [FW-1:0]         n_dlt_acc;
    logic [FW-1:0]         n_prev;
    logic                  n_out_valid;
    ntfsdr_pkg::t_status   n_out_status;
    logic [FW-1:0]         n_out_len;
    logic [FW-1:0]         n_out_start;

    logic advance;
    logic take;

    // effective state after an optional list restart
    t_phase        e_phase;
    logic [SW-1:0] e_count;
    logic [SW-1:0] e_dlt_bytes;
    logic [SW-1:0] e_len_bytes;
    logic [FW-1:0] e_len_acc;
    logic [FW-1:0] e_dlt_acc;
    logic [FW-1:0] e_prev;

    logic [SW-1:0] hdr_len;
    logic [SW-1:0] hdr_dlt;
    logic [SW-1:0] cnt_inc;
    logic [FW-1:0] len_merge;
    logic [FW-1:0] dlt_merge;
    logic [FW-1:0] dlt_ext;
    logic [FW-1:0] cluster_sum;

    // pipeline moves when the result register is free or being drained
    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;
    assign take       = r_in_valid && advance;

    // restart clears parser and running cluster ahead of this byte
    always_comb begin
        if (r_in_start) begin
            e_phase     = PH_HEADER;
            e_count     = '0;
            e_len_bytes = '0;
            e_dlt_bytes = '0;
            e_len_acc   = '0;
            e_dlt_acc   = '0;
            e_prev      = '0;
        end else begin
            e_phase     = r_phase;
            e_count     = r_count;
            e_len_bytes = r_len_bytes;
            e_dlt_bytes = r_dlt_bytes;
            e_len_acc   = r_len_acc;
            e_dlt_acc   = r_dlt_acc;
            e_prev      = r_prev;
        end
    end

    assign hdr_len = r_in_byte[SW-1:0];
    assign hdr_dlt = r_in_byte[BW-1:SW];
    assign cnt_inc = e_count + SW'(1);

    // place the byte into its lane; delta lanes above it take its sign
    always_comb begin
        for (int k = 0; k < NL; k++) begin
            if (SW'(k) == e_count) begin
                len_merge[k*BW +: BW] = r_in_byte;
                dlt_merge[k*BW +: BW] = r_in_byte;
                dlt_ext[k*BW +: BW]   = r_in_byte;
            end else begin
                len_merge[k*BW +: BW] = e_len_acc[k*BW +: BW];
                dlt_merge[k*BW +: BW] = e_dlt_acc[k*BW +: BW];
                if (SW'(k) < e_count) begin
                    dlt_ext[k*BW +: BW] = e_dlt_acc[k*BW +: BW];
                end else begin
                    dlt_ext[k*BW +: BW] = {BW{r_in_byte[BW-1]}};
                end
            end
        end
    end

    assign cluster_sum = e_prev + dlt_ext;

    // decode the byte into next parser state and result
    always_comb begin
        n_phase      = r_phase;
        n_count      = r_count;
        n_len_bytes  = r_len_bytes;
        n_dlt_bytes  = r_dlt_bytes;
        n_len_acc    = r_len_acc;
        n_dlt_acc    = r_dlt_acc;
        n_prev       = r_prev;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_len    = r_out_len;
        n_out_start  = r_out_start;

        // drop a delivered result
        if (advance) begin
            n_out_valid = 1'b0;
        end

        if (take) begin
            n_phase     = e_phase;
            n_count     = e_count;
            n_len_bytes = e_len_bytes;
            n_dlt_bytes = e_dlt_bytes;
            n_len_acc   = e_len_acc;
            n_dlt_acc   = e_dlt_acc;
            n_prev      = e_prev;

            unique case (e_phase)
                PH_HEADER: begin
                    if (r_in_byte == '0) begin
                        n_phase      = PH_STOP;
                        n_out_valid  = 1'b1;
                        n_out_status = ntfsdr_pkg::ST_END;
                        n_out_len    = '0;
                        n_out_start  = '0;
                    end else if (hdr_len == '0
                                 || hdr_len > ntfsdr_pkg::MAX_FIELD_BYTES
                                 || hdr_dlt > ntfsdr_pkg::MAX_FIELD_BYTES) begin
                        n_phase      = PH_STOP;
                        n_out_valid  = 1'b1;
                        n_out_status = ntfsdr_pkg::ST_BAD;
                        n_out_len    = '0;
                        n_out_start  = '0;
                    end else begin
                        n_phase     = PH_LENGTH;
                        n_len_bytes = hdr_len;
                        n_dlt_bytes = hdr_dlt;
                        n_count     = '0;
                        n_len_acc   = '0;
                        n_dlt_acc   = '0;
                    end
                end
                PH_LENGTH: begin
                    n_len_acc = len_merge;
                    if (cnt_inc >= e_len_bytes) begin
                        n_count = '0;
                        if (e_dlt_bytes == '0) begin
                            n_phase      = PH_HEADER;
                            n_out_valid  = 1'b1;
                            n_out_status = ntfsdr_pkg::ST_RUN;
                            n_out_len    = len_merge;
                            n_out_start  = e_prev;
                        end else begin
                            n_phase = PH_DELTA;
                        end
                    end else begin
                        n_count = cnt_inc;
                    end
                end
                PH_DELTA: begin
                    n_dlt_acc = dlt_merge;
                    if (cnt_inc >= e_dlt_bytes) begin
                        n_count      = '0;
                        n_phase      = PH_HEADER;
                        n_prev       = cluster_sum;
                        n_out_valid  = 1'b1;
                        n_out_status = ntfsdr_pkg::ST_RUN;
                        n_out_len    = e_len_acc;
                        n_out_start  = cluster_sum;
                    end else begin
                        n_count = cnt_inc;
                    end
                end
                PH_STOP: begin
                    n_phase = PH_STOP;
                end
                default: begin
                    n_phase = PH_STOP;
                end
            endcase
        end
    end

    // parser state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_HEADER;
            r_count     <= '0;
            r_len_bytes <= '0;
            r_dlt_bytes <= '0;
            r_len_acc   <= '0;
            r_dlt_acc   <= '0;
            r_prev      <= '0;
        end else begin
            // capture input byte
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
                r_in_byte  <= i_s_tdata;
                r_in_start <= i_s_tuser;
            end

            r_phase      <= n_phase;
            r_count      <= n_count;
            r_len_bytes  <= n_len_bytes;
            r_dlt_bytes  <= n_dlt_bytes;
            r_len_acc    <= n_len_acc;
            r_dlt_acc    <= n_dlt_acc;
            r_prev       <= n_prev;
            r_out_valid  <= n_out_valid;
            r_out_status <= n_out_status;
            r_out_len    <= n_out_len;
            r_out_start  <= n_out_start;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_start, r_out_len};
    assign o_m_tuser  = r_out_status;

endmodule

// ----- dv/ntfsdr_sb_pkg.sv -----
// ----------------------------------------------------------------------------
// ntfsdr_sb_pkg
// Run list scoreboard: decodes each accepted byte in step with the block and
// queues the run, end and error results it should produce, then checks every
// result transfer against the oldest queued one.
// ----------------------------------------------------------------------------
package ntfsdr_sb_pkg;

    localparam int unsigned BYTE_W   = ntfsdr_pkg::BYTE_W;
    localparam int unsigned FIELD_W  = ntfsdr_pkg::FIELD_W;
    localparam int unsigned SIZE_W   = ntfsdr_pkg::SIZE_W;
    localparam int unsigned STATUS_W = ntfsdr_pkg::STATUS_W;

    localparam logic [SIZE_W-1:0] MAX_FIELD_BYTES = ntfsdr_pkg::MAX_FIELD_BYTES;

    // Parser position within the run list
    typedef enum logic [1:0] {
        PARSE_HEADER,
        PARSE_LENGTH,
        PARSE_DELTA,
        PARSE_STOPPED
    } t_parse_state;

    typedef struct packed {
        ntfsdr_pkg::t_status status;
        logic [FIELD_W-1:0]  run_length;
        logic [FIELD_W-1:0]  start_cluster;
    } t_run_result;

    class run_list_checker;
        t_run_result        expected_runs[$];
        int                 mismatch_count;
        t_parse_state       parse_state;
        logic [SIZE_W-1:0]  gathered;
        logic [SIZE_W-1:0]  length_size;
        logic [SIZE_W-1:0]  delta_size;
        logic [FIELD_W-1:0] length_acc;
        logic [FIELD_W-1:0] delta_acc;
        logic [FIELD_W-1:0] cluster;

        function new();
            mismatch_count = 0;
            clear_list();
        endfunction

        // Return the parser and the running cluster to their reset values
        function void clear_list();
            parse_state = PARSE_HEADER;
            gathered    = '0;
            length_size = '0;
            delta_size  = '0;
            length_acc  = '0;
            delta_acc   = '0;
            cluster     = '0;
        endfunction

        function int pending();
            return expected_runs.size();
        endfunction

        // Sign-fill the delta, advance the cluster and queue the run
        function void close_run();
            logic [FIELD_W-1:0] delta;
            int                 top;
            delta = delta_acc;
            top   = int'(delta_size) * BYTE_W;
            if (delta_size != 0 && delta_size < MAX_FIELD_BYTES && delta[top-1])
                delta |= {FIELD_W{1'b1}} << top;
            cluster    += delta;
            parse_state = PARSE_HEADER;
            expected_runs.push_back('{status: ntfsdr_pkg::ST_RUN, run_length: length_acc,
                                      start_cluster: cluster});
        endfunction

        // Note one accepted byte and queue whatever result it completes
        function void take_byte(logic [BYTE_W-1:0] value, logic first);
            logic [SIZE_W-1:0] lsz;
            logic [SIZE_W-1:0] dsz;
            if (first)
                clear_list();
            lsz = value[3:0];
            dsz = value[7:4];
            case (parse_state)
                PARSE_HEADER: begin
                    if (value == '0) begin
                        parse_state = PARSE_STOPPED;
                        expected_runs.push_back('{status: ntfsdr_pkg::ST_END, run_length: '0,
                                                  start_cluster: '0});
                    end else if (lsz == 0 || lsz > MAX_FIELD_BYTES || dsz > MAX_FIELD_BYTES) begin
                        parse_state = PARSE_STOPPED;
                        expected_runs.push_back('{status: ntfsdr_pkg::ST_BAD, run_length: '0,
                                                  start_cluster: '0});
                    end else begin
                        length_size = lsz;
                        delta_size  = dsz;
                        gathered    = '0;
                        length_acc  = '0;
                        delta_acc   = '0;
                        parse_state = PARSE_LENGTH;
                    end
                end
                PARSE_LENGTH: begin
                    length_acc |= FIELD_W'(value) << (int'(gathered[2:0]) * BYTE_W);
                    gathered    = gathered + 1'b1;
                    if (gathered >= length_size) begin
                        gathered = '0;
                        if (delta_size == 0)
                            close_run();
                        else
                            parse_state = PARSE_DELTA;
                    end
                end
                PARSE_DELTA: begin
                    delta_acc |= FIELD_W'(value) << (int'(gathered[2:0]) * BYTE_W);
                    gathered   = gathered + 1'b1;
                    if (gathered >= delta_size) begin
                        gathered = '0;
                        close_run();
                    end
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what, logic [FIELD_W-1:0] got, logic [FIELD_W-1:0] want);
            mismatch_count++;
            $display("%0t mismatch: %s got 0x%h expected 0x%h", $realtime, what, got, want);
        endtask

        // Compare one result transfer with the oldest queued result
        task check_run(logic [STATUS_W-1:0] status, logic [FIELD_W-1:0] run_length,
                       logic [FIELD_W-1:0] start_cluster);
            t_run_result want;
            if (expected_runs.size() == 0) begin
                report_mismatch("unexpected result, status", FIELD_W'(status), '0);
                return;
            end
            want = expected_runs.pop_front();
            if (status !== want.status)
                report_mismatch("status", FIELD_W'(status), FIELD_W'(want.status));
            if (run_length !== want.run_length)
                report_mismatch("run_length", run_length, want.run_length);
            if (start_cluster !== want.start_cluster)
                report_mismatch("start_cluster", start_cluster, want.start_cluster);
        endtask

        // Flag results that never arrived
        task flush_check();
            if (expected_runs.size() != 0)
                report_mismatch("results never delivered, count", '0,
                                FIELD_W'(expected_runs.size()));
        endtask
    endclass

endpackage

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stream testbench for the NTFS data run decoder: a directed run list covering
// size extremes, end and bad headers and list restarts, then random run lists
// under three idle patterns, with every result checked by the scoreboard.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BYTE_W   = ntfsdr_pkg::BYTE_W;
    localparam int unsigned FIELD_W  = ntfsdr_pkg::FIELD_W;
    localparam int unsigned SIZE_W   = ntfsdr_pkg::SIZE_W;
    localparam int unsigned STATUS_W = ntfsdr_pkg::STATUS_W;

    localparam logic [SIZE_W-1:0] MAX_FIELD_BYTES = ntfsdr_pkg::MAX_FIELD_BYTES;

    localparam int STALL_LIMIT           = 4000;
    localparam int DRAIN_CYCLES          = 8;
    localparam int RESET_CYCLES          = 11;
    localparam int RANDOM_BYTES_PER_PASS = 300;

    localparam logic [BYTE_W-1:0] END_OF_LIST = 8'h00;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [2*FIELD_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    int                            send_idle_pct = 36;
    int                            recv_idle_pct = 83;
    int                            live_bytes    = 0;
    int                            stall_cycles  = 0;
    ntfsdr_sb_pkg::run_list_checker runs;

    ntfs_data_run_decoder_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),      // [7:0] run_byte
        .i_s_tuser  (s_tuser),      // [0] start_list
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),      // [63:0] run_length, [127:64] start_cluster
        .o_m_tuser  (m_tuser)       // [1:0] status
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Check each result transfer, then pick the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            runs.check_run(m_tuser, m_tdata[FIELD_W-1:0], m_tdata[2*FIELD_W-1:FIELD_W]);
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // End the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Byte values with the all-zero and all-one extremes made common
    function automatic logic [BYTE_W-1:0] random_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Nonzero header whose length or delta size is out of range
    function automatic logic [BYTE_W-1:0] bad_header();
        logic [BYTE_W-1:0] h;
        do begin
            h = 8'($urandom);
        end while (h == END_OF_LIST ||
                   (h[3:0] != 0 && h[3:0] <= MAX_FIELD_BYTES && h[7:4] <= MAX_FIELD_BYTES));
        return h;
    endfunction

    // Offer one byte after a random gap and hold it until transferred
    task automatic send_byte(input logic [BYTE_W-1:0] value, input logic first);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= first;
        do begin
            @(posedge i_clk);
        end while (!s_tready);
        runs.take_byte(value, first);
        live_bytes++;
    endtask

    // Bytes sent while the decoder is stopped do not count as work
    task automatic send_ignored(input int count);
        repeat (count) begin
            send_byte(random_byte(), 1'b0);
            live_bytes--;
        end
    endtask

    // Header plus its fields; cut drops the tail of the run
    task automatic send_run(input logic first, input logic cut);
        logic [SIZE_W-1:0] lsz;
        logic [SIZE_W-1:0] dsz;
        int                body;
        lsz  = SIZE_W'($urandom_range(1, MAX_FIELD_BYTES));
        dsz  = SIZE_W'($urandom_range(0, MAX_FIELD_BYTES));
        body = int'(lsz) + int'(dsz);
        send_byte({dsz, lsz}, first);
        if (cut)
            body = $urandom_range(0, body - 1);
        repeat (body) send_byte(random_byte(), 1'b0);
    endtask

    // Hold the sender until every queued result has been delivered
    task automatic drain_pause();
        s_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (runs.pending() != 0);
    endtask

    task automatic directed_list();
        // single byte fields, negative delta
        send_byte(8'h11, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        // zero delta size keeps the previous cluster
        send_byte(8'h01, 1'b0);
        send_byte(8'h05, 1'b0);
        // widest fields: all-ones length, 8-byte delta with top bit set
        send_byte(8'h88, 1'b0);
        repeat (MAX_FIELD_BYTES) send_byte(8'hFF, 1'b0);
        repeat (MAX_FIELD_BYTES) send_byte(8'h80, 1'b0);
        // end of list, then a byte that must be dropped
        send_byte(END_OF_LIST, 1'b0);
        send_ignored(1);
        // bad sizes: length too big, delta too big, zero length
        send_byte(8'h09, 1'b1);
        send_byte(8'hF1, 1'b1);
        send_byte(8'h10, 1'b1);
        // restart in the middle of a delta drops the partial run
        send_byte(8'h21, 1'b1);
        send_byte(8'h05, 1'b0);
        send_byte(8'h12, 1'b1);
        send_byte(8'h34, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'hFE, 1'b0);
    endtask

    // Mostly well-formed run lists, with ends, bad headers, cut runs and noise
    task automatic random_pass(input int target);
        int   stop_at;
        int   pick;
        logic restart;
        stop_at = live_bytes + target;
        restart = 1'b1;
        while (live_bytes < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                send_run(restart || $urandom_range(19) == 0, 1'b0);
                restart = 1'b0;
            end else if (pick < 86) begin
                send_byte(END_OF_LIST, restart);
                send_ignored($urandom_range(2));
                restart = 1'b1;
            end else if (pick < 92) begin
                send_byte(bad_header(), restart);
                send_ignored($urandom_range(2));
                restart = 1'b1;
            end else if (pick < 96) begin
                send_run(restart, 1'b1);
                restart = 1'b1;
            end else begin
                repeat ($urandom_range(1, 4)) send_byte(random_byte(), $urandom_range(3) == 0);
                restart = 1'b1;
            end
        end
    endtask

    initial begin
        runs = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles lightly, receiver heavily
        directed_list();
        random_pass(RANDOM_BYTES_PER_PASS);
        drain_pause();

        // sender idles heavily, receiver lightly
        send_idle_pct = 83;
        recv_idle_pct = 36;
        random_pass(RANDOM_BYTES_PER_PASS);
        drain_pause();

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_pass(RANDOM_BYTES_PER_PASS);
        s_tvalid <= 1'b0;

        while (runs.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        runs.flush_check();

        if (runs.mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
